// File: src/wind_chill_index_macros.svh
// Assertion macros for the wind chill index RTL.
`ifndef WIND_CHILL_INDEX_MACROS_SVH
`define WIND_CHILL_INDEX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/wci_pkg.sv
// Shared widths, coefficients and the power table helper for the wind chill index.
`default_nettype none

package wci_pkg;

    // Field widths
    localparam int TEMP_W  = 11;
    localparam int WIND_W  = 12;
    localparam int CHILL_W = 13;
    localparam int POW_W   = 19;

    // Output saturation bounds
    localparam int CHILL_MAX = 2 ** (CHILL_W - 1) - 1;
    localparam int CHILL_MIN = -(2 ** (CHILL_W - 1));

    // Parameter defaults
    localparam int DEF_FRACTION_BITS       = 4;
    localparam int DEF_POWER_TABLE_ENTRIES = 256;

    // Formula coefficients in Q16
    localparam int K_OFFSET = 859832;
    localparam int K_TEMP   = 40731;
    localparam int K_WIND   = 745144;
    localparam int K_CROSS  = 25985;

    // Thresholds: warm air at 10 C, light wind at 4.8 km/h (24/5)
    localparam int WARM_DEG   = 10;
    localparam int LIGHT_NUM  = 24;
    localparam int LIGHT_DEN  = 5;

    // floor(2^16 * x^0.16) for table point k, where x = k * step km/h.
    // The small guard keeps exact powers (x of one) from flooring low.
    function automatic logic [POW_W-1:0] power_point(input int k, input real step);
        real x;
        real v;
        x = real'(k) * step;
        v = $floor(65536.0 * $pow(x, 0.16) + 1.0e-7);
        return POW_W'($rtoi(v));
    endfunction

endpackage

`default_nettype wire

// File: src/wci_in_if.sv
// Input channel carrying one temperature and wind speed sample per beat.
`default_nettype none

interface wci_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wci_pkg::TEMP_W-1:0]    air_temperature;
    logic        [wci_pkg::WIND_W-1:0]    wind_kmh;

    modport source (output valid, output air_temperature, output wind_kmh, input ready);
    modport sink   (input valid, input air_temperature, input wind_kmh, output ready);
endinterface

`default_nettype wire

// File: src/wci_out_if.sv
// Output channel carrying one wind chill result per beat.
`default_nettype none

interface wci_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wci_pkg::CHILL_W-1:0]   chill_temperature;
    logic                                 formula_applied;

    modport source (output valid, output chill_temperature, output formula_applied,
                    input ready);
    modport sink   (input valid, input chill_temperature, input formula_applied,
                    output ready);
endinterface

`default_nettype wire

// File: src/wci_power_interp.sv
// Three-stage table lookup with linear interpolation of wind^0.16 in Q16.
`default_nettype none

module wci_power_interp #(
    parameter int FRACTION_BITS       = wci_pkg::DEF_FRACTION_BITS,
    parameter int POWER_TABLE_ENTRIES = wci_pkg::DEF_POWER_TABLE_ENTRIES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [wci_pkg::WIND_W-1:0]  i_wind,
    output logic      [wci_pkg::POW_W-1:0]   o_power
);
    import wci_pkg::*;

    localparam int  IdxW     = $clog2(POWER_TABLE_ENTRIES);
    localparam int  PosW     = WIND_W + $clog2(POWER_TABLE_ENTRIES + 1);
    localparam int  ProdW    = POW_W + WIND_W;
    localparam real WindStep = 4096.0 /
                               (real'(POWER_TABLE_ENTRIES) * (2.0 ** FRACTION_BITS));

    // Each entry holds the point value and the rise to the next point.
    typedef logic [2*POW_W-1:0] t_rom [POWER_TABLE_ENTRIES];

    function automatic t_rom build_rom();
        t_rom              rom;
        logic [POW_W-1:0]  lo;
        logic [POW_W-1:0]  hi;
        for (int k = 0; k < POWER_TABLE_ENTRIES; k++) begin
            lo     = power_point(k, WindStep);
            hi     = power_point(k + 1, WindStep);
            rom[k] = {lo, hi - lo};
        end
        return rom;
    endfunction

    localparam t_rom PowerRom = build_rom();

    logic [PosW-1:0]     w_pos;
    logic [IdxW-1:0]     w_idx;
    logic [2*POW_W-1:0]  w_entry;

    logic [POW_W-1:0]    r_base1;
    logic [POW_W-1:0]    r_diff1;
    logic [WIND_W-1:0]   r_frac1;
    logic [POW_W-1:0]    r_base2;
    logic [ProdW-1:0]    r_prod2;
    logic [POW_W-1:0]    r_power3;

    // Split the scaled wind into table index and fraction
    assign w_pos   = PosW'(i_wind) * PosW'(POWER_TABLE_ENTRIES);
    assign w_idx   = w_pos[WIND_W +: IdxW];
    assign w_entry = PowerRom[w_idx];

    // Stage 1: table read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base1 <= w_entry[2*POW_W-1:POW_W];
            r_diff1 <= w_entry[POW_W-1:0];
            r_frac1 <= w_pos[WIND_W-1:0];
        end
    end

    // Stage 2: scale the rise by the fraction
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base2 <= r_base1;
            r_prod2 <= ProdW'(r_diff1) * ProdW'(r_frac1);
        end
    end

    // Stage 3: add the interpolated step to the base point
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_power3 <= r_base2 + r_prod2[ProdW-1:WIND_W];
        end
    end

    assign o_power = r_power3;

endmodule

`default_nettype wire

// File: src/wind_chill_index.sv
// Wind chill index top level: six-stage pipeline from sample to chill temperature.
// Throughput: one sample per cycle; the whole pipe holds while the output stage is full
// and not taken, so input ready is output ready or an empty output stage, and low in reset.
// Reset clears every stage valid bit; payload registers keep their contents.
`default_nettype none

module wind_chill_index #(
    parameter int FRACTION_BITS       = wci_pkg::DEF_FRACTION_BITS,
    parameter int POWER_TABLE_ENTRIES = wci_pkg::DEF_POWER_TABLE_ENTRIES
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wci_in_if.sink      i_sample,
    wci_out_if.source   o_chill
);
    import wci_pkg::*;

`include "wind_chill_index_macros.svh"

    localparam int SumW       = 48 + FRACTION_BITS;
    localparam int QW         = SumW - 32;
    localparam int LightW     = WIND_W + 3;
    localparam int WarmLimit  = WARM_DEG * (2 ** FRACTION_BITS);
    localparam int LightLimit = LIGHT_NUM * (2 ** FRACTION_BITS);
    localparam int TtW        = 17 + TEMP_W;
    localparam int CtW        = 16 + TEMP_W;
    localparam int CrossW     = CtW + POW_W + 1;
    localparam int WindTW     = 20 + POW_W;

    localparam logic signed [SumW-1:0] OffsetTerm = SumW'(K_OFFSET) << (16 + FRACTION_BITS);
    localparam logic signed [SumW-1:0] RoundHalf  = SumW'(1) << 31;
    localparam logic signed [QW-1:0]   ChillMaxQ  = QW'(CHILL_MAX);
    localparam logic signed [QW-1:0]   ChillMinQ  = QW'(CHILL_MIN);
    localparam logic signed [16:0]     KTempS     = 17'(K_TEMP);
    localparam logic signed [15:0]     KCrossS    = 16'(K_CROSS);
    localparam logic        [19:0]     KWindU     = 20'(K_WIND);

    logic                        w_adv;
    logic                        w_warm;
    logic                        w_light;
    logic [POW_W-1:0]            w_power;
    logic signed [SumW-1:0]      w_round;
    logic signed [QW-1:0]        w_q;
    logic signed [CHILL_W-1:0]   w_sat;

    logic                        r_vld1, r_vld2, r_vld3, r_vld4, r_vld5, r_vld6;
    logic signed [TEMP_W-1:0]    r_t1, r_t2, r_t3, r_t4, r_t5;
    logic                        r_pass1, r_pass2, r_pass3, r_pass4, r_pass5;
    logic signed [TtW-1:0]       r_tt2, r_tt3, r_tt4;
    logic signed [CtW-1:0]       r_ct2, r_ct3;
    logic signed [CrossW-1:0]    r_cross4;
    logic        [WindTW-1:0]    r_wind4;
    logic signed [SumW-1:0]      r_sum5;
    logic signed [CHILL_W-1:0]   r_chill6;
    logic                        r_applied6;

    // Advance the whole pipe unless a finished beat waits at the output
    assign w_adv          = !r_vld6 || o_chill.ready;
    assign i_sample.ready = w_adv && i_rst_n;

    // Detect the pass-through cases on the incoming sample
    assign w_warm  = int'(i_sample.air_temperature) > WarmLimit;
    assign w_light = (LightW'(i_sample.wind_kmh) * LightW'(LIGHT_DEN)) < LightW'(LightLimit);

    // Power term, aligned with stage 3
    wci_power_interp #(
        .FRACTION_BITS       (FRACTION_BITS),
        .POWER_TABLE_ENTRIES (POWER_TABLE_ENTRIES)
    ) u_power (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_wind  (i_sample.wind_kmh),
        .o_power (w_power)
    );

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else if (w_adv) begin
            r_vld1 <= i_sample.valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
        end
    end

    // Stages 1 to 3: capture the sample, form the temperature products
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t1    <= i_sample.air_temperature;
            r_pass1 <= w_warm || w_light;

            r_t2    <= r_t1;
            r_pass2 <= r_pass1;
            r_tt2   <= TtW'(KTempS) * TtW'(r_t1);
            r_ct2   <= CtW'(KCrossS) * CtW'(r_t1);

            r_t3    <= r_t2;
            r_pass3 <= r_pass2;
            r_tt3   <= r_tt2;
            r_ct3   <= r_ct2;
        end
    end

    // Stage 4: multiply the power term into the wind and cross terms
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t4     <= r_t3;
            r_pass4  <= r_pass3;
            r_tt4    <= r_tt3;
            r_cross4 <= CrossW'(r_ct3) * CrossW'($signed({1'b0, w_power}));
            r_wind4  <= WindTW'(KWindU) * WindTW'(w_power);
        end
    end

    // Stage 5: sum all terms in Q(32+FB)
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t5    <= r_t4;
            r_pass5 <= r_pass4;
            r_sum5  <= OffsetTerm + (SumW'(r_tt4) <<< 16)
                     - (SumW'(r_wind4) << FRACTION_BITS) + SumW'(r_cross4);
        end
    end

    // Round half up to Q(FB) and saturate
    always_comb begin
        w_round = r_sum5 + RoundHalf;
        w_q     = w_round[SumW-1:32];
        if (w_q > ChillMaxQ) begin
            w_sat = CHILL_W'(CHILL_MAX);
        end else if (w_q < ChillMinQ) begin
            w_sat = CHILL_W'(CHILL_MIN);
        end else begin
            w_sat = w_q[CHILL_W-1:0];
        end
    end

    // Stage 6: output register, pass-through or formula result
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_chill6   <= r_pass5 ? CHILL_W'(r_t5) : w_sat;
            r_applied6 <= !r_pass5;
        end
    end

    assign o_chill.valid             = r_vld6;
    assign o_chill.chill_temperature = r_chill6;
    assign o_chill.formula_applied   = r_applied6;

    // Checks
    `WCI_ASSERT_NOW(a_ready_only_blocked_by_output, i_clk, i_rst_n,
        !i_sample.ready, r_vld6 && !o_chill.ready, "input stalled without a held output beat")
    `WCI_ASSERT_NEXT(a_stage5_reaches_output, i_clk, i_rst_n,
        r_vld5 && w_adv, r_vld6, "beat lost between sum stage and output")
    `WCI_ASSERT_NOW(a_passthrough_in_temp_range, i_clk, i_rst_n,
        r_vld6 && !r_applied6, r_chill6 >= -13'sd1024 && r_chill6 <= 13'sd1023,
        "pass-through result outside the temperature range")

endmodule

`default_nettype wire
